// File: rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, constants and item tables of the tiered poll scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int NUM_ITEMS_DEF = 10;
  localparam int TIME_BITS_DEF = 48;

  localparam int TABLE_LEN     = 10;
  localparam int NOW_BITS      = 48;
  localparam int ID_BITS       = 8;
  localparam int MASK_BITS     = 10;
  localparam int PERIOD_BITS   = 32;
  localparam int ITEM_IDX_BITS = 5;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [PERIOD_BITS-1:0] FAIL_DELAY = 32'd2000;
  localparam logic [PERIOD_BITS-1:0] GAP_FLOOR  = 32'd100;

  localparam logic [CFG_IDX_BITS-1:0] REG_SUPPORTED_MASK = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAST_PERIOD    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEDIUM_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_PERIOD    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_GAP        = 3'd4;

  typedef enum logic [1:0] {
    TIER_FAST,
    TIER_MEDIUM,
    TIER_SLOW
  } tier_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAIL,
    ST_CHECK,
    ST_SCAN,
    ST_PICK,
    ST_GAP,
    ST_OUT
  } state_t;

  function automatic logic [ID_BITS-1:0] item_id(input logic [ITEM_IDX_BITS-1:0] idx);
    logic [ID_BITS-1:0] id;
    case (idx)
      5'd0:    id = 8'h0C;
      5'd1:    id = 8'h0D;
      5'd2:    id = 8'h11;
      5'd3:    id = 8'h0B;
      5'd4:    id = 8'h04;
      5'd5:    id = 8'h10;
      5'd6:    id = 8'h05;
      5'd7:    id = 8'h0F;
      5'd8:    id = 8'h42;
      5'd9:    id = 8'h2F;
      default: id = 8'h00;
    endcase
    return id;
  endfunction

  function automatic tier_t item_tier(input logic [ITEM_IDX_BITS-1:0] idx);
    tier_t tier;
    case (idx)
      5'd0, 5'd1, 5'd2: tier = TIER_FAST;
      5'd3, 5'd4, 5'd5: tier = TIER_MEDIUM;
      default:          tier = TIER_SLOW;
    endcase
    return tier;
  endfunction

endpackage

// File: rtl/tps_if.sv
// ----------------------------------------------------------------------------
// tps_if
// Valid/ready channels of the tiered poll scheduler: poll requests in and
// pick results out.
// ----------------------------------------------------------------------------
interface tps_poll_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [tps_pkg::NOW_BITS-1:0]  now;

  modport source (output valid, func, now, input ready);
  modport sink   (input valid, func, now, output ready);
endinterface

interface tps_pick_if;
  logic                          valid;
  logic                          ready;
  logic                          pick_valid;
  logic [tps_pkg::ID_BITS-1:0]   pick_id;

  modport source (output valid, pick_valid, pick_id, input ready);
  modport sink   (input valid, pick_valid, pick_id, output ready);
endinterface

// File: rtl/tps_sat_add.sv
// ----------------------------------------------------------------------------
// tps_sat_add
// Shared saturating adder: a time plus a 32-bit period, clamped to the
// largest time value.
// ----------------------------------------------------------------------------
module tps_sat_add #(
  parameter int TIME_BITS = tps_pkg::TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0]            a,
  input  logic [tps_pkg::PERIOD_BITS-1:0] b,
  output logic [TIME_BITS-1:0]            sum
);

  logic [TIME_BITS:0] wide;

  always_comb begin
    wide = {1'b0, a} + (TIME_BITS+1)'(b);
    // The time maximum is all ones, so a carry out is the only overflow.
    if (wide[TIME_BITS]) begin
      sum = '1;
    end else begin
      sum = wide[TIME_BITS-1:0];
    end
  end

endmodule

// File: rtl/tiered_poll_scheduler.sv
// ----------------------------------------------------------------------------
// tiered_poll_scheduler
// Chooses the next polled item to request from a table of items with rate
// tiers, spacing requests by a minimum gap and backing off after failures.
// ----------------------------------------------------------------------------
// Order: a failure request goes through FAIL to OUT, and a poll before the next-request time
// through CHECK to OUT; any other poll scans min(NUM_ITEMS,10) due times, one per cycle,
// then goes through PICK, through GAP when an item is picked, and to OUT. Throughput: one
// request at a time; the next is accepted in the cycle after the result is taken. Synchronous
// reset clears all due times and the next-request time and loads the register reset values.
module tiered_poll_scheduler #(
  parameter int NUM_ITEMS = tps_pkg::NUM_ITEMS_DEF,
  parameter int TIME_BITS = tps_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  tps_poll_if.sink                          poll_in,
  tps_pick_if.source                        pick_out,
  input  logic                              cfg_we,
  input  logic [tps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tps_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int SCAN_LEN = (NUM_ITEMS < tps_pkg::TABLE_LEN) ? NUM_ITEMS : tps_pkg::TABLE_LEN;
  localparam int IDX_BITS = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SCAN_LEN - 1);

  tps_pkg::state_t state, state_next;

  logic [tps_pkg::MASK_BITS-1:0]   supported_mask;
  logic [tps_pkg::PERIOD_BITS-1:0] fast_period_ms;
  logic [tps_pkg::PERIOD_BITS-1:0] medium_period_ms;
  logic [tps_pkg::PERIOD_BITS-1:0] slow_period_ms;
  logic [tps_pkg::PERIOD_BITS-1:0] min_gap_ms;

  logic [TIME_BITS-1:0] due_time [NUM_ITEMS];
  logic [TIME_BITS-1:0] next_request_time;

  logic                 now_lt_next;
  logic [TIME_BITS-1:0] now_r;
  logic                 func_r;
  logic [IDX_BITS-1:0]  idx;
  logic [IDX_BITS-1:0]  choice;
  logic [TIME_BITS-1:0] best_due;
  logic                 found;
  logic                 res_valid;
  logic [tps_pkg::ID_BITS-1:0] res_id;

  logic [NUM_ITEMS-1:0]            sup_ext;
  logic [TIME_BITS-1:0]            scan_due;
  logic                            take;
  logic [tps_pkg::PERIOD_BITS-1:0] period;
  logic [tps_pkg::PERIOD_BITS-1:0] gap;
  logic [tps_pkg::PERIOD_BITS-1:0] add_b;
  logic [TIME_BITS-1:0]            add_sum;

  tps_sat_add #(.TIME_BITS(TIME_BITS)) u_add (
    .a   (now_r),
    .b   (add_b),
    .sum (add_sum)
  );

  always_comb begin
    sup_ext     = NUM_ITEMS'(supported_mask);
    scan_due    = due_time[idx];
    take        = sup_ext[idx] && (scan_due <= now_r) && (!found || scan_due < best_due);
    now_lt_next = now_r < next_request_time;

    case (tps_pkg::item_tier(tps_pkg::ITEM_IDX_BITS'(choice)))
      tps_pkg::TIER_FAST:   period = fast_period_ms;
      tps_pkg::TIER_MEDIUM: period = medium_period_ms;
      default:              period = slow_period_ms;
    endcase
    if (period == '0) begin
      period = tps_pkg::PERIOD_BITS'(1);
    end
    gap = (min_gap_ms < tps_pkg::GAP_FLOOR) ? tps_pkg::GAP_FLOOR : min_gap_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    add_b          = gap;
    poll_in.ready  = 1'b0;
    pick_out.valid = 1'b0;
    case (state)
      tps_pkg::ST_IDLE: begin
        poll_in.ready = 1'b1;
        if (poll_in.valid) begin
          state_next = poll_in.func ? tps_pkg::ST_FAIL : tps_pkg::ST_CHECK;
        end
      end
      tps_pkg::ST_FAIL: begin
        add_b      = tps_pkg::FAIL_DELAY;
        state_next = tps_pkg::ST_OUT;
      end
      tps_pkg::ST_CHECK: begin
        state_next = now_lt_next ? tps_pkg::ST_OUT : tps_pkg::ST_SCAN;
      end
      tps_pkg::ST_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = tps_pkg::ST_PICK;
        end
      end
      tps_pkg::ST_PICK: begin
        add_b      = period;
        state_next = found ? tps_pkg::ST_GAP : tps_pkg::ST_OUT;
      end
      tps_pkg::ST_GAP: begin
        state_next = tps_pkg::ST_OUT;
      end
      tps_pkg::ST_OUT: begin
        pick_out.valid = 1'b1;
        if (pick_out.ready) begin
          state_next = tps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tps_pkg::ST_IDLE;
      end
    endcase
  end

  assign pick_out.pick_valid = res_valid;
  assign pick_out.pick_id    = res_id;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      supported_mask   <= '0;
      fast_period_ms   <= 32'd200;
      medium_period_ms <= 32'd1000;
      slow_period_ms   <= 32'd5000;
      min_gap_ms       <= 32'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        tps_pkg::REG_SUPPORTED_MASK: supported_mask   <= cfg_data[tps_pkg::MASK_BITS-1:0];
        tps_pkg::REG_FAST_PERIOD:    fast_period_ms   <= cfg_data;
        tps_pkg::REG_MEDIUM_PERIOD:  medium_period_ms <= cfg_data;
        tps_pkg::REG_SLOW_PERIOD:    slow_period_ms   <= cfg_data;
        tps_pkg::REG_MIN_GAP:        min_gap_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scheduler state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ITEMS; i++) begin
        due_time[i] <= '0;
      end
      next_request_time <= '0;
    end else begin
      case (state)
        tps_pkg::ST_FAIL: next_request_time <= add_sum;
        tps_pkg::ST_PICK: begin
          if (found) begin
            due_time[choice] <= add_sum;
          end
        end
        tps_pkg::ST_GAP:  next_request_time <= add_sum;
        default: ;
      endcase
    end
  end

  // Request capture, scan and result registers.
  always_ff @(posedge clk) begin
    case (state)
      tps_pkg::ST_IDLE: begin
        if (poll_in.valid) begin
          func_r    <= poll_in.func;
          now_r     <= TIME_BITS'(poll_in.now);
          res_valid <= 1'b0;
          res_id    <= '0;
        end
      end
      tps_pkg::ST_CHECK: begin
        idx   <= '0;
        found <= 1'b0;
      end
      tps_pkg::ST_SCAN: begin
        // Strict compare keeps the lowest index on equal due times.
        if (take) begin
          found    <= 1'b1;
          choice   <= idx;
          best_due <= scan_due;
        end
        if (idx != LAST_IDX) begin
          idx <= idx + IDX_BITS'(1);
        end
      end
      tps_pkg::ST_GAP: begin
        res_valid <= !func_r;
        res_id    <= tps_pkg::item_id(tps_pkg::ITEM_IDX_BITS'(choice));
      end
      default: ;
    endcase
  end

endmodule

// File: tb/sv/tiered_poll_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_poll_scheduler_tb
// Self-checking bench for the tiered poll scheduler. It sends poll and failure
// requests with random gaps, stalls the pick side at random, and compares each
// pick against an in-bench model of the due-time table and request spacing.
// ----------------------------------------------------------------------------
localparam logic                              FUNC_POLL       = 1'b0;
localparam logic                              FUNC_FAIL       = 1'b1;
localparam logic [tps_pkg::CFG_IDX_BITS-1:0]  REG_UNMAPPED_LO = 3'd5;
localparam logic [tps_pkg::CFG_IDX_BITS-1:0]  REG_UNMAPPED    = 3'd7;
localparam logic [tps_pkg::NOW_BITS-1:0]      TIME_MAX        = {tps_pkg::NOW_BITS{1'b1}};

typedef struct packed {
  logic                        pick_valid;
  logic [tps_pkg::ID_BITS-1:0] pick_id;
} pick_t;

class pick_tracker;
  logic [tps_pkg::MASK_BITS-1:0]   supported;
  logic [tps_pkg::PERIOD_BITS-1:0] fast_ms, mid_ms, slow_ms, gap_ms;
  logic [tps_pkg::NOW_BITS-1:0]    due_ms [tps_pkg::TABLE_LEN];
  logic [tps_pkg::NOW_BITS-1:0]    next_req_ms;
  logic [tps_pkg::ID_BITS-1:0]     item_code [tps_pkg::TABLE_LEN];
  tps_pkg::tier_t                  item_rate [tps_pkg::TABLE_LEN];
  pick_t                           expected_picks [$];
  int                              errors;

  function new();
    item_code = '{8'h0C, 8'h0D, 8'h11, 8'h0B, 8'h04, 8'h10, 8'h05, 8'h0F, 8'h42, 8'h2F};
    item_rate = '{tps_pkg::TIER_FAST, tps_pkg::TIER_FAST, tps_pkg::TIER_FAST,
                  tps_pkg::TIER_MEDIUM, tps_pkg::TIER_MEDIUM, tps_pkg::TIER_MEDIUM,
                  tps_pkg::TIER_SLOW, tps_pkg::TIER_SLOW, tps_pkg::TIER_SLOW,
                  tps_pkg::TIER_SLOW};
    supported   = '0;
    fast_ms     = 32'd200;
    mid_ms      = 32'd1000;
    slow_ms     = 32'd5000;
    gap_ms      = tps_pkg::GAP_FLOOR;
    foreach (due_ms[i]) due_ms[i] = '0;
    next_req_ms = '0;
    errors      = 0;
  endfunction

  function void write_reg(logic [tps_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [tps_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      tps_pkg::REG_SUPPORTED_MASK: supported = data[tps_pkg::MASK_BITS-1:0];
      tps_pkg::REG_FAST_PERIOD:    fast_ms   = data;
      tps_pkg::REG_MEDIUM_PERIOD:  mid_ms    = data;
      tps_pkg::REG_SLOW_PERIOD:    slow_ms   = data;
      tps_pkg::REG_MIN_GAP:        gap_ms    = data;
      default: ;
    endcase
  endfunction

  // Time plus a period, clamped at the largest representable time.
  function logic [tps_pkg::NOW_BITS-1:0] sat_add(logic [tps_pkg::NOW_BITS-1:0] a,
                                                 logic [tps_pkg::PERIOD_BITS-1:0] b);
    logic [tps_pkg::NOW_BITS:0] s;
    s = {1'b0, a} + {{(tps_pkg::NOW_BITS + 1 - tps_pkg::PERIOD_BITS){1'b0}}, b};
    return s[tps_pkg::NOW_BITS] ? TIME_MAX : s[tps_pkg::NOW_BITS-1:0];
  endfunction

  function void accept_poll(logic op, logic [tps_pkg::NOW_BITS-1:0] now_ms);
    pick_t                           exp;
    int                              choice;
    logic [tps_pkg::PERIOD_BITS-1:0] period;
    exp    = '0;
    choice = -1;
    if (op == FUNC_FAIL) begin
      next_req_ms = sat_add(now_ms, tps_pkg::FAIL_DELAY);
    end else if (now_ms >= next_req_ms) begin
      for (int i = 0; i < tps_pkg::TABLE_LEN; i++) begin
        if (supported[i] && due_ms[i] <= now_ms &&
            (choice < 0 || due_ms[i] < due_ms[choice])) begin
          choice = i;
        end
      end
      if (choice >= 0) begin
        case (item_rate[choice])
          tps_pkg::TIER_FAST:   period = fast_ms;
          tps_pkg::TIER_MEDIUM: period = mid_ms;
          default:              period = slow_ms;
        endcase
        if (period == '0) period = 32'd1;
        due_ms[choice] = sat_add(now_ms, period);
        next_req_ms    = sat_add(now_ms, (gap_ms < tps_pkg::GAP_FLOOR) ?
                                         tps_pkg::GAP_FLOOR : gap_ms);
        exp.pick_valid = 1'b1;
        exp.pick_id    = item_code[choice];
      end
    end
    expected_picks = {expected_picks, exp};
  endfunction

  function void check_pick(logic got_valid, logic [tps_pkg::ID_BITS-1:0] got_id);
    pick_t exp;
    if (expected_picks.size() == 0) begin
      $display("%0t: pick with no request outstanding: pick_valid %0b pick_id %h",
               $time, got_valid, got_id);
      errors++;
      return;
    end
    exp = expected_picks.pop_front();
    if (got_valid !== exp.pick_valid) begin
      $display("%0t: pick_valid expected %0b actual %0b", $time, exp.pick_valid, got_valid);
      errors++;
    end
    if (got_id !== exp.pick_id) begin
      $display("%0t: pick_id expected %h actual %h", $time, exp.pick_id, got_id);
      errors++;
    end
  endfunction
endclass

module tiered_poll_scheduler_tb;
  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [tps_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [tps_pkg::CFG_DATA_BITS-1:0] cfg_data;
  bit                                quiet;
  logic [tps_pkg::NOW_BITS-1:0]      clock_ms;
  pick_tracker                       tracker = new();

  tps_poll_if poll_ch();
  tps_pick_if pick_ch();

  tiered_poll_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .poll_in   (poll_ch),
    .pick_out  (pick_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Mostly back-to-back, sometimes a short pause, now and then a long pause.
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [tps_pkg::CFG_DATA_BITS-1:0] rand_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return $urandom;
      default: return $urandom_range(2, 1500);
    endcase
  endfunction

  function automatic logic [tps_pkg::CFG_DATA_BITS-1:0] rand_gap();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd99;
      2:       return 32'd100;
      3:       return 32'd101;
      4:       return '1;
      5:       return $urandom;
      default: return $urandom_range(100, 400);
    endcase
  endfunction

  function automatic logic [tps_pkg::CFG_DATA_BITS-1:0] rand_mask();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return 32'd1 << $urandom_range(0, tps_pkg::MASK_BITS - 1);
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Small steps keep items coming due; rare large jumps get past huge gaps.
  function automatic logic [tps_pkg::NOW_BITS-1:0] advance(logic [tps_pkg::NOW_BITS-1:0] t);
    logic [tps_pkg::NOW_BITS-1:0] step;
    if ($urandom_range(0, 99) < 94) step = tps_pkg::NOW_BITS'($urandom_range(0, 400));
    else step = tps_pkg::NOW_BITS'($urandom) << $urandom_range(0, 4);
    return (t > TIME_MAX - step) ? TIME_MAX : t + step;
  endfunction

  initial begin : pick_side
    int stall;
    stall = 0;
    pick_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pick_ch.valid && pick_ch.ready) begin
        tracker.check_pick(pick_ch.pick_valid, pick_ch.pick_id);
      end
      if (stall > 0) begin
        pick_ch.ready <= 1'b0;
        stall--;
      end else begin
        pick_ch.ready <= 1'b1;
        stall = idle_len();
      end
    end
  end

  // Valid is left high after acceptance; the next call either lowers it for a
  // gap or replaces the payload, so it never toggles within one step.
  task automatic send_poll(logic op, logic [tps_pkg::NOW_BITS-1:0] t);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_ch.valid <= 1'b1;
    poll_ch.func  <= op;
    poll_ch.now   <= t;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
    tracker.accept_poll(op, t);
  endtask

  task automatic wait_idle();
    poll_ch.valid <= 1'b0;
    while (tracker.expected_picks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [tps_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [tps_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [tps_pkg::CFG_DATA_BITS-1:0] mask,
                           logic [tps_pkg::CFG_DATA_BITS-1:0] fast_val,
                           logic [tps_pkg::CFG_DATA_BITS-1:0] mid_val,
                           logic [tps_pkg::CFG_DATA_BITS-1:0] slow_val,
                           logic [tps_pkg::CFG_DATA_BITS-1:0] gap_val);
    wait_idle();
    write_reg(tps_pkg::REG_MIN_GAP, gap_val);
    write_reg(tps_pkg::REG_SLOW_PERIOD, slow_val);
    write_reg(tps_pkg::REG_MEDIUM_PERIOD, mid_val);
    write_reg(tps_pkg::REG_FAST_PERIOD, fast_val);
    write_reg(tps_pkg::REG_SUPPORTED_MASK, mask);
  endtask

  task automatic run_phase(int n_items, bit wide_noise);
    int                           hold_at;
    int                           r;
    logic [tps_pkg::NOW_BITS-1:0] t;
    hold_at = $urandom_range(0, n_items - 1);
    for (int k = 0; k < n_items; k++) begin
      if (k == hold_at) wait_idle();
      r = $urandom_range(0, 99);
      if (r < 72) begin
        clock_ms = advance(clock_ms);
        send_poll(FUNC_POLL, clock_ms);
      end else if (r < 82) begin
        clock_ms = advance(clock_ms);
        send_poll(FUNC_FAIL, clock_ms);
      end else if (r < 94) begin
        t = tps_pkg::NOW_BITS'($urandom_range(1, 5000));
        send_poll(FUNC_POLL, (clock_ms > t) ? clock_ms - t : '0);
      end else if (wide_noise) begin
        t = tps_pkg::NOW_BITS'({$urandom, $urandom});
        send_poll(1'($urandom_range(0, 1)), t);
      end else begin
        send_poll(FUNC_POLL, clock_ms);
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= tps_pkg::REG_SUPPORTED_MASK;
    cfg_data      <= '0;
    poll_ch.valid <= 1'b0;
    poll_ch.func  <= FUNC_POLL;
    poll_ch.now   <= '0;
    quiet    = 1'b0;
    clock_ms = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Nothing is supported after reset, so wide times leave the table alone.
    send_poll(FUNC_POLL, '0);
    send_poll(FUNC_POLL, TIME_MAX);
    send_poll(FUNC_POLL, {24{2'b10}});
    send_poll(FUNC_POLL, {24{2'b01}});
    send_poll(FUNC_FAIL, TIME_MAX);
    send_poll(FUNC_POLL, 48'd1000);
    send_poll(FUNC_FAIL, '0);
    send_poll(FUNC_POLL, 48'd1999);

    configure('1, '0, 32'd1, 32'd5000, '0);
    write_reg(REG_UNMAPPED, '1);
    write_reg(REG_UNMAPPED_LO, $urandom);

    // All due times equal: lowest index first, then each of the rest in turn.
    send_poll(FUNC_POLL, 48'd2000);
    send_poll(FUNC_POLL, 48'd2099);
    for (int k = 1; k < tps_pkg::TABLE_LEN; k++) begin
      send_poll(FUNC_POLL, 48'd2000 + 48'd100 * k);
    end
    send_poll(FUNC_FAIL, 48'd3000);
    send_poll(FUNC_POLL, 48'd5000);
    clock_ms = 48'd5000;

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        configure('1, '0, '0, '0, '0);
      end else if (p == 1) begin
        configure('1, '1, '1, '1, '1);
      end else if (p == 7) begin
        // Close to the top of the time range so sums can saturate.
        clock_ms = TIME_MAX - tps_pkg::NOW_BITS'($urandom_range(0, 50000));
        configure(rand_mask(), rand_period(), rand_period(), rand_period(), rand_gap());
      end else begin
        configure(rand_mask(), rand_period(), rand_period(), rand_period(), rand_gap());
      end
      quiet = (p == 3) || ($urandom_range(0, 4) == 0);
      run_phase(66, p == 7);
    end

    quiet = 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_picks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
